@@ sv/crcfd_pkg.sv @@
// ============================================================================
// crcfd_pkg
// Shared types, constants and the CRC byte update of the packet deframer.
// ============================================================================
`default_nettype none

package crcfd_pkg;

	localparam int unsigned POS_W = 17;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0] MAGIC_A = 8'h4F;
	localparam logic [7:0] MAGIC_B = 8'h31;
	localparam logic [7:0] VERSION_ID = 8'h01;
	localparam logic [POS_W-1:0] HDR_SIZE = 17'd8;
	localparam logic [15:0] MAX_PAYLOAD_DEF = 16'd1024;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_HEADER = 2'd1,
		ST_LENGTH = 2'd2,
		ST_CRC = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic is_last;
	} item_t;

	typedef struct packed {
		logic [15:0] payload_length;
		logic [15:0] sequence_res;
		logic [7:0] frame_type;
		status_t status;
		logic frame_end;
		logic [7:0] payload_byte;
		logic payload_valid;
	} result_t;

	// CRC-16/CCITT-FALSE: one byte, MSB first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ sv/crc_framed_packet_decoder.sv @@
// ============================================================================
// crc_framed_packet_decoder
// Streaming deframer for CRC-16/CCITT-FALSE protected packets.
// ============================================================================
// Usage:
//   Frame bytes enter on the s_ channel, one item per byte, with s_tlast on
//   the final byte of each frame. Every item gives exactly one result on the
//   m_ channel: the byte itself when it lies in the declared payload
//   (m_tuser bit 0 set), plus the header fields captured so far. On the
//   result with m_tlast set, m_tuser[2:1] carries the frame status: ok, bad
//   header or too short, bad length, or CRC mismatch. Drop any payload
//   already forwarded unless that status is ok.
//   Pipeline: two register stages (input register, then result register);
//   an item is taken into the input register and its result into the result register.
//   Throughput: one item per cycle while m_tready holds no result back; the
//   byte-wide CRC update and header state feeding the next byte are combinational.
//   Reset: all frame state returns to its idle values (CRC 0xFFFF, position
//   zero); both stages empty. Frame state also clears after every last byte.
//   Stall: while m_tready is low the result register holds; one further
//   item waits in the input register, then s_tready drops.
// ============================================================================
`default_nettype none

module crc_framed_packet_decoder #(
	parameter logic [15:0] MAX_PAYLOAD = crcfd_pkg::MAX_PAYLOAD_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata, // rx_byte
	input wire logic s_tlast, // is_last
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [47:0] m_tdata, // payload_byte, frame_type, sequence_res, payload_length
	output logic m_tlast, // frame_end
	output logic [2:0] m_tuser // payload_valid, status[1:0]
);
	import crcfd_pkg::*;

	item_t item_s1;
	logic valid_s1;
	logic advance;
	result_t res;
	result_t res_q;
	logic out_valid_q;

	// advance the input item when the result register is free or drains
	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.rx_byte <= s_tdata;
			item_s1.is_last <= s_tlast;
		end
	end

	crcfd_parse #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.item(item_s1),
		.res(res)
	);

	// result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {res_q.payload_length, res_q.sequence_res, res_q.frame_type,
		res_q.payload_byte};
	assign m_tlast = res_q.frame_end;
	assign m_tuser = {res_q.status, res_q.payload_valid};

endmodule

`default_nettype wire

@@ sv/crcfd_parse.sv @@
// ============================================================================
// crcfd_parse
// Frame state and per-byte evaluation: header capture, CRC, status.
// ============================================================================
`default_nettype none

module crcfd_parse #(
	parameter logic [15:0] MAX_PAYLOAD = crcfd_pkg::MAX_PAYLOAD_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic advance,
	input wire crcfd_pkg::item_t item,
	output crcfd_pkg::result_t res
);
	import crcfd_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [15:0] crc_q;
	logic [7:0] held0_q;
	logic [7:0] held1_q;
	logic hdr_bad_q;
	logic [7:0] type_q;
	logic [15:0] seq_q;
	logic [15:0] len_q;

	logic [15:0] crc_d;
	logic hdr_bad_d;
	logic [7:0] type_d;
	logic [15:0] seq_d;
	logic [15:0] len_d;
	logic pv;
	logic [POS_W-1:0] pay_off;
	logic [POS_W:0] end_pos;
	status_t st;

	always_comb begin
		hdr_bad_d = hdr_bad_q;
		type_d = type_q;
		seq_d = seq_q;
		len_d = len_q;
		unique case (pos_q)
			17'd0: hdr_bad_d = hdr_bad_q | (item.rx_byte != MAGIC_A);
			17'd1: hdr_bad_d = hdr_bad_q | (item.rx_byte != MAGIC_B);
			17'd2: hdr_bad_d = hdr_bad_q | (item.rx_byte != VERSION_ID);
			17'd3: type_d = item.rx_byte;
			17'd4: seq_d = {seq_q[15:8], item.rx_byte};
			17'd5: seq_d = {item.rx_byte, seq_q[7:0]};
			17'd6: len_d = {len_q[15:8], item.rx_byte};
			17'd7: len_d = {item.rx_byte, len_q[7:0]};
			default: begin
			end
		endcase
	end

	// the two newest bytes stay out of the CRC; at frame end they are the received CRC
	assign crc_d = (pos_q >= 17'd2) ? crc_feed(crc_q, held0_q) : crc_q;

	assign pay_off = pos_q - HDR_SIZE;
	assign pv = (pos_q >= HDR_SIZE) && (pay_off < {1'b0, len_d});
	assign end_pos = {2'b00, len_d} + 18'd9;

	always_comb begin
		priority if (pos_q < 17'd9 || hdr_bad_d) begin
			st = ST_HEADER;
		end else if (len_d > MAX_PAYLOAD || {1'b0, pos_q} != end_pos) begin
			st = ST_LENGTH;
		end else if (crc_d == {item.rx_byte, held1_q}) begin
			st = ST_OK;
		end else begin
			st = ST_CRC;
		end
	end

	always_comb begin
		res.payload_valid = pv;
		res.payload_byte = pv ? item.rx_byte : 8'h00;
		res.frame_end = item.is_last;
		res.status = item.is_last ? st : ST_OK;
		res.frame_type = type_d;
		res.sequence_res = seq_d;
		res.payload_length = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= CRC_INIT;
			held0_q <= '0;
			held1_q <= '0;
			hdr_bad_q <= 1'b0;
			type_q <= '0;
			seq_q <= '0;
			len_q <= '0;
		end else if (advance) begin
			if (item.is_last) begin
				pos_q <= '0;
				crc_q <= CRC_INIT;
				held0_q <= '0;
				held1_q <= '0;
				hdr_bad_q <= 1'b0;
				type_q <= '0;
				seq_q <= '0;
				len_q <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 17'd1;
				end
				crc_q <= crc_d;
				held0_q <= held1_q;
				held1_q <= item.rx_byte;
				hdr_bad_q <= hdr_bad_d;
				type_q <= type_d;
				seq_q <= seq_d;
				len_q <= len_d;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/crcfd_checker.sv @@
// ============================================================================
// crcfd_checker
// Port-level checks on the deframer's channels.
// ============================================================================
`default_nettype none

module crcfd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic [7:0] s_tdata,
	input wire logic s_tlast,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic m_tlast,
	input wire logic [2:0] m_tuser
);

	// an offered item waits unchanged until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
		else $error("offered item changed before it was taken");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("result changed while stalled");

	// status is only reported at frame end
	a_status_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser[2:1] == 2'd0)
		else $error("status outside frame end");

	// bytes outside the payload are zeroed
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'h00)
		else $error("non-payload byte not zero");

endmodule

bind crc_framed_packet_decoder crcfd_checker u_crcfd_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
// ============================================================================
// tb_top
// Self-checking bench for the CRC-framed packet deframer.
// ============================================================================
// Frames are built here, each as a queue of bytes, and fed to the s_ channel
// with random gaps. Every accepted item runs through a cycle-free model of the
// deframer. The model holds its own copy of the header capture, position
// counter, CRC and two-byte delay line. Its prediction goes into a FIFO, and
// each m_ result is checked field by field against the oldest entry.
// Phases:
//   - directed: tiny frames, a clean empty frame, bad magic, both length
//     extremes
//   - random: mostly well-formed frames, the rest broken in every way the
//     status codes distinguish, plus noise
// The receiver also holds off once for a long stretch so that the block
// backs up and stalls its input; after each phase the sender waits until
// every predicted result has come.
// ============================================================================

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import crcfd_pkg::*;

	localparam logic [15:0] MAX_PAYLOAD = MAX_PAYLOAD_DEF;
	localparam int unsigned RANDOM_ITEMS = 560;
	localparam int unsigned HOLD_AFTER = 300;      // results before the long hold-off
	localparam int unsigned HOLD_CYCLES = 240;

	// Ways a random frame is built or broken
	typedef enum int {
		FR_GOOD,
		FR_BAD_MAGIC,
		FR_BAD_VERSION,
		FR_BAD_CRC,
		FR_LEN_MISMATCH,
		FR_LEN_OVER,
		FR_SHORT,
		FR_NOISE
	} frame_kind_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;   // rx_byte
	logic s_tlast = 1'b0;          // is_last
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;          // payload_byte, frame_type, sequence_res, payload_length
	logic m_tlast;                 // frame_end
	logic [2:0] m_tuser;           // payload_valid, status[1:0]

	crc_framed_packet_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Deframer model state: cleared at reset and after every last byte
	// ------------------------------------------------------------------------
	logic [POS_W-1:0] frame_pos;
	logic [15:0] crc_acc;
	logic [7:0] delay_old;   // older of the two held-back bytes
	logic [7:0] delay_new;
	logic hdr_broken;
	logic [7:0] got_type;
	logic [15:0] got_seq;
	logic [15:0] got_len;

	item_t pending_bytes[$];        // items waiting for the driver
	result_t frame_results[$];      // predicted results, oldest first
	logic [7:0] frame_buf[$];       // frame under construction
	int unsigned stim_count = 0;
	int unsigned errors = 0;
	int unsigned results_seen = 0;
	int unsigned tx_gap, tx_quiet, rx_stall, rx_quiet;
	int unsigned hold_left;
	bit hold_done;

	function automatic void clear_frame_state();
		frame_pos = '0;
		crc_acc = CRC_INIT;
		delay_old = 8'h00;
		delay_new = 8'h00;
		hdr_broken = 1'b0;
		got_type = 8'h00;
		got_seq = 16'h0000;
		got_len = 16'h0000;
	endfunction

	// Add one byte at the tail of the frame under construction
	function automatic void append_byte(logic [7:0] b);
		frame_buf.insert(frame_buf.size(), b);
	endfunction

	// Shift one byte through the CRC, data bit against the top bit of the register
	function automatic logic [15:0] crc16_byte(logic [15:0] acc, logic [7:0] data);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = acc[15] ^ data[i];
			acc = {acc[14:0], 1'b0};
			if (fb) begin
				acc = acc ^ CRC_POLY;
			end
		end
		return acc;
	endfunction

	// Advance the model by one frame byte and return the result it causes
	function automatic result_t deframe_step(logic [7:0] b, logic last);
		result_t r;
		logic [POS_W:0] frame_size;
		logic pv;
		case (frame_pos)
			17'd0: if (b != MAGIC_A) hdr_broken = 1'b1;
			17'd1: if (b != MAGIC_B) hdr_broken = 1'b1;
			17'd2: if (b != VERSION_ID) hdr_broken = 1'b1;
			17'd3: got_type = b;
			17'd4: got_seq[7:0] = b;
			17'd5: got_seq[15:8] = b;
			17'd6: got_len[7:0] = b;
			17'd7: got_len[15:8] = b;
			default: ;
		endcase
		// the two newest bytes stay out of the CRC; at frame end they are the received CRC
		if (frame_pos >= 17'd2) begin
			crc_acc = crc16_byte(crc_acc, delay_old);
		end
		delay_old = delay_new;
		delay_new = b;
		pv = (frame_pos >= HDR_SIZE) && ((frame_pos - HDR_SIZE) < {1'b0, got_len});

		r.payload_valid = pv;
		r.payload_byte = pv ? b : 8'h00;
		r.frame_end = last;
		r.status = ST_OK;
		r.frame_type = got_type;
		r.sequence_res = got_seq;
		r.payload_length = got_len;
		if (last) begin
			frame_size = {1'b0, frame_pos} + 18'd1;
			if (frame_size < 18'd10 || hdr_broken) begin
				r.status = ST_HEADER;
			end else if (got_len > MAX_PAYLOAD || frame_size != 18'd10 + {2'b00, got_len}) begin
				r.status = ST_LENGTH;
			end else if (crc_acc != {delay_new, delay_old}) begin
				r.status = ST_CRC;
			end
			clear_frame_state();
		end else if (frame_pos != POS_MAX) begin
			frame_pos = frame_pos + 17'd1;
		end
		return r;
	endfunction

	// Mostly no idling, sometimes a short gap, now and then a long gap
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 30);
	endfunction

	function automatic void check_field(string fname, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
			errors++;
		end
	endfunction

	// Header, random payload of plen bytes, CRC; the declared length may lie
	task automatic build_frame(int unsigned plen, logic [15:0] declared, logic [7:0] ftype,
			logic [15:0] seq);
		logic [15:0] acc;
		frame_buf.delete();
		append_byte(MAGIC_A);
		append_byte(MAGIC_B);
		append_byte(VERSION_ID);
		append_byte(ftype);
		append_byte(seq[7:0]);
		append_byte(seq[15:8]);
		append_byte(declared[7:0]);
		append_byte(declared[15:8]);
		repeat (plen) append_byte(8'($urandom));
		acc = CRC_INIT;
		foreach (frame_buf[i]) acc = crc16_byte(acc, frame_buf[i]);
		append_byte(acc[7:0]);
		append_byte(acc[15:8]);
	endtask

	// Hand the frame to the driver, marking its final byte
	task automatic flush_frame();
		item_t it;
		foreach (frame_buf[i]) begin
			it.rx_byte = frame_buf[i];
			it.is_last = (i == frame_buf.size() - 1);
			pending_bytes.insert(pending_bytes.size(), it);
		end
		stim_count += frame_buf.size();
	endtask

	// Hold the sender until the block has delivered every predicted result
	task automatic drain();
		while (pending_bytes.size() != 0 || s_tvalid || frame_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: offer the next pending item, predict it when it is accepted
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_items
		item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tlast <= 1'b0;
			tx_gap = 0;
			tx_quiet = 0;
			clear_frame_state();
		end else begin
			if (s_tvalid && s_tready) begin
				frame_results.insert(frame_results.size(), deframe_step(s_tdata, s_tlast));
			end
			// the offered item is held until taken
			if (!s_tvalid || s_tready) begin
				if (tx_gap != 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					nxt = pending_bytes.pop_front();
					s_tdata <= nxt.rx_byte;
					s_tlast <= nxt.is_last;
					s_tvalid <= 1'b1;
					if (tx_quiet != 0) begin
						tx_quiet--;
						tx_gap = 0;
					end else begin
						if ($urandom_range(0, 59) == 0) tx_quiet = $urandom_range(20, 80);
						tx_gap = idle_len();
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check every accepted result against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : watch_results
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			results_seen <= 0;
			rx_stall = 0;
			rx_quiet = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (frame_results.size() == 0) begin
					$error("result with no prediction waiting");
					errors++;
				end else begin
					want = frame_results.pop_front();
					check_field("payload_valid", want.payload_valid, m_tuser[0]);
					check_field("status", int'(want.status), m_tuser[2:1]);
					check_field("frame_end", want.frame_end, m_tlast);
					check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
					check_field("frame_type", want.frame_type, m_tdata[15:8]);
					check_field("sequence_res", want.sequence_res, m_tdata[31:16]);
					check_field("payload_length", want.payload_length, m_tdata[47:32]);
				end
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (rx_stall != 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (rx_quiet != 0) begin
					rx_quiet--;
					rx_stall = 0;
				end else begin
					if ($urandom_range(0, 59) == 0) rx_quiet = $urandom_range(20, 80);
					rx_stall = idle_len();
				end
			end
		end
	end

	// One long hold-off on the receive side, counted here; the sender keeps going
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int unsigned plen, r, cut, idx, base;
		logic [15:0] declared;
		frame_kind_e kind;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single magic byte as a whole frame: too short, no header captured
		frame_buf.delete();
		append_byte(MAGIC_A);
		flush_frame();
		// full header then one byte: still too short, type and sequence at their top values, declared length zero
		build_frame(0, 16'h0000, 8'hFF, 16'hFFFF);
		void'(frame_buf.pop_back());
		flush_frame();
		// smallest clean frame
		build_frame(0, 16'h0000, 8'h00, 16'h0000);
		flush_frame();
		// second magic byte wrong
		build_frame(0, 16'h0000, 8'h5A, 16'hA55A);
		frame_buf[1] = 8'h32;
		flush_frame();
		// longest legal payload, then the largest declared length on a tiny frame
		build_frame(MAX_PAYLOAD, MAX_PAYLOAD, 8'($urandom), 16'($urandom));
		flush_frame();
		build_frame(2, 16'hFFFF, 8'($urandom), 16'($urandom));
		flush_frame();
		drain();

		// random frames, most of them well formed
		base = stim_count;
		while (stim_count - base < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 62) kind = FR_GOOD;
			else if (r < 68) kind = FR_BAD_MAGIC;
			else if (r < 72) kind = FR_BAD_VERSION;
			else if (r < 80) kind = FR_BAD_CRC;
			else if (r < 86) kind = FR_LEN_MISMATCH;
			else if (r < 90) kind = FR_LEN_OVER;
			else if (r < 95) kind = FR_SHORT;
			else kind = FR_NOISE;

			r = $urandom_range(0, 99);
			if (r < 80) plen = $urandom_range(0, 16);
			else if (r < 98) plen = $urandom_range(17, 80);
			else plen = $urandom_range(81, 300);

			declared = 16'(plen);
			if (kind == FR_LEN_MISMATCH) begin
				if (plen > 0 && $urandom_range(0, 1) == 1) begin
					declared = 16'(plen - $urandom_range(1, (plen < 3) ? plen : 3));
				end else begin
					declared = 16'(plen + $urandom_range(1, 3));
				end
			end else if (kind == FR_LEN_OVER) begin
				declared = $urandom_range(0, 1) ? MAX_PAYLOAD + 16'd1
						: 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
			end
			build_frame(plen, declared, 8'($urandom), 16'($urandom));

			case (kind)
				FR_BAD_MAGIC: begin
					idx = $urandom_range(0, 1);
					frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
				end
				FR_BAD_VERSION: frame_buf[2] = frame_buf[2] ^ 8'($urandom_range(1, 255));
				FR_BAD_CRC: begin
					// flip one bit in the payload or the CRC itself
					idx = $urandom_range(8, frame_buf.size() - 1);
					frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
				end
				FR_SHORT: begin
					cut = $urandom_range(1, 9);
					while (frame_buf.size() > cut) void'(frame_buf.pop_back());
				end
				FR_NOISE: begin
					frame_buf.delete();
					repeat ($urandom_range(1, 14)) append_byte(8'($urandom));
					if ($urandom_range(0, 1) == 1) frame_buf[0] = MAGIC_A;
				end
				default: ;
			endcase
			flush_frame();
		end
		drain();

		// let any stray result surface
		repeat (20) @(negedge clk);
		if (errors == 0 && frame_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#30ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ crc_framed_packet_decoder.f @@
sv/crcfd_pkg.sv
sv/crcfd_parse.sv
sv/crc_framed_packet_decoder.sv
sv/crcfd_checker.sv
tb/tb_top.sv
